[hw/rtl/ssat_pkg.sv]
// Package for the slew-shaped saturator: fixed-point constants, register map,
// sequencer state types and the sine-series divisor table.
// No dependencies; compiled before every other file of the block.
package ssat_pkg;

  // Q.24 constants used by the soft limiter and the drive stage.
  localparam int unsigned SIN_W = 25;  // holds values up to and including 1.0
  localparam int unsigned SQ_W  = 26;  // holds x^2 and the series products
  localparam int unsigned DIV_W = 7;   // widest series divisor
  localparam int unsigned SIN_TERMS = 5;

  localparam logic [SIN_W-1:0] Q_ONE     = 25'h100_0000;
  localparam logic [SIN_W-1:0] HALF_PI_Q = 25'd26353589;
  localparam logic [31:0] DRIVE_GAIN_Q   = 32'd2264924;
  localparam logic [31:0] DRIVE_INV_Q    = 32'd124275674;

  // APB register map, one 32-bit register per word.
  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_SLEW_GAIN      = 3'd0,
    REG_INV_SLEW_GAIN  = 3'd1,
    REG_PREV_SLEW_GAIN = 3'd2,
    REG_BALANCE_RAW    = 3'd3,
    REG_BALANCE_HELD   = 3'd4
  } cfg_reg_e;

  localparam logic [31:0] RST_SLEW_GAIN      = 32'd3489661;
  localparam logic [31:0] RST_INV_SLEW_GAIN  = 32'd80659691;
  localparam logic [31:0] RST_PREV_SLEW_GAIN = 32'd5586813;
  localparam logic [31:0] RST_BALANCE_RAW    = 32'd1678;
  localparam logic [31:0] RST_BALANCE_HELD   = 32'd16775538;

  // Sequencer states of the sample datapath.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SLEW,
    ST_SIN_SQ,
    ST_SIN_MT,
    ST_SIN_DIV,
    ST_SIN_FIN,
    ST_LM,
    ST_MIXH,
    ST_MIXR,
    ST_MIXS,
    ST_COMB,
    ST_SUB1,
    ST_SUB2,
    ST_Y,
    ST_DRV,
    ST_OUT,
    ST_EMIT
  } state_e;

  // Where the shared sine routine returns to.
  typedef enum logic {
    RET_SLEW,
    RET_DRIVE
  } ret_e;

  // Divisors of the Horner series, innermost term first.
  function automatic logic [DIV_W-1:0] sine_div(input logic [2:0] k);
    logic [DIV_W-1:0] d;
    case (k)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/ssat_stream_if.sv]
// Valid/ready stream interfaces carrying the input and output samples.
// Standalone; used by the slew_shaped_saturator top level.
interface ssat_in_if #(parameter int SAMPLE_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface ssat_out_if #(parameter int SAMPLE_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

[hw/rtl/ssat_mul.sv]
// Bit-serial shift-add multiplier with Q.24 round-to-nearest of the product.
// Standalone; instantiated by the slew_shaped_saturator top level.
module ssat_mul #(
  parameter int unsigned AW = 42,
  parameter int unsigned BW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [AW-1:0]       a_i,
  input  logic [BW-1:0]       b_i,
  output logic                done_o,
  output logic [AW+BW-24:0]   res_o
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned RW = PW - 23;
  localparam int unsigned CW = $clog2(BW);

  logic [AW-1:0] mc_q;
  logic [BW-1:0] mp_q;
  logic [PW-1:0] acc_q, acc_d;
  logic [AW:0]   sum;
  logic [PW:0]   rsum;
  logic [CW-1:0] cnt_q;
  logic          run_q, rnd_q, done_q;
  logic [RW-1:0] res_q;

  // One multiplier bit per cycle: add the multiplicand into the top half, shift right.
  assign sum   = {1'b0, acc_q[PW-1:BW]} + (mp_q[0] ? {1'b0, mc_q} : '0);
  assign acc_d = {sum, acc_q[BW-1:1]};

  // Round to nearest at bit 24.
  assign rsum = {1'b0, acc_q} + (PW+1)'(24'h80_0000);

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= rnd_q;
      rnd_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(BW - 1)) begin
          run_q <= 1'b0;
          rnd_q <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= a_i;
      mp_q  <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_d;
      mp_q  <= mp_q >> 1;
    end
    if (rnd_q) begin
      res_q <= rsum[PW:24];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/slew_shaped_saturator.sv]
// Slew-shaped saturator: one multiplier, shared bit-serially, and a sequencer.
// The latency from input transfer to valid result depends on the input: each product runs
// bit-serially through ssat_mul, inputs below 1.0 add one comb product, and each of the two sine evaluations
// adds 7 products and 5 serial divisions. One sample is in flight; the next
// is accepted in the same cycle as a result is presented.
// Reset restores register defaults and clears history. Depends on ssat_pkg, ssat_stream_if, ssat_mul.
module slew_shaped_saturator
  import ssat_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssat_in_if.sink           in_if,
  ssat_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int MW = W + 10;
  localparam int RW = MW + 9;
  localparam int SW = (RW + 1 > 42) ? RW + 1 : 42;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SW-1:0] CAP_HI = {{(SW-41){1'b0}}, 1'b1, 40'b0};
  localparam logic signed [SW-1:0] CAP_LO = (~CAP_HI) + SW'(1);

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sval(input logic neg, input logic [RW-1:0] r);
    logic [SW-1:0] e;
    e = SW'(r);
    return neg ? -e : e;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] m;
    m = v[SW-1] ? -v : v;
    return m[MW-1:0];
  endfunction

  // Configuration registers.
  logic [31:0] slew_gain_q, inv_slew_gain_q, prev_slew_gain_q;
  logic [31:0] balance_raw_q, balance_held_q;
  logic        cfg_wr;

  // Sequencer and datapath registers.
  state_e                state_q, state_d;
  ret_e                  ret_q, ret_d;
  logic signed [W-1:0]   x_q, x_d, lim_q, lim_d, mix_q, mix_d;
  logic signed [W-1:0]   prior_input_q, prior_input_d;
  logic signed [W-1:0]   prior_mix_q, prior_mix_d;
  logic signed [W-1:0]   prior_slew_q, prior_slew_d;
  logic signed [W-1:0]   out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic                  slew_neg_q, slew_neg_d, yneg_q, yneg_d;
  logic signed [SW-1:0]  acc_q, acc_d;
  logic [SIN_W-1:0]      sx_q, sx_d, st_q, st_d;
  logic [SQ_W-1:0]       sx2_q, sx2_d, dq_q, dq_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [2:0]            k_q, k_d;
  logic [4:0]            dcnt_q, dcnt_d;

  // Multiplier hookup.
  logic                  mul_start, mul_done;
  logic [MW-1:0]         mul_a;
  logic [31:0]           mul_b;
  logic [RW-1:0]         mul_res;

  // Shared combinational terms.
  logic signed [SW-1:0]  slew_v, y_cap;
  logic signed [W-1:0]   lim_v;
  logic [MW-1:0]         x_mag, pm_mag, ps_mag;
  logic                  res_gt_pi;
  logic [SIN_W-1:0]      res_sin, res_q1, t_n;
  logic [DIV_W:0]        trial, rem_full;
  logic                  div_ge;
  logic [SQ_W-1:0]       dq_n;

  ssat_mul #(
    .AW(MW),
    .BW(32)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // APB register file; a write completes in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_SLEW_GAIN:      prdata = slew_gain_q;
      REG_INV_SLEW_GAIN:  prdata = inv_slew_gain_q;
      REG_PREV_SLEW_GAIN: prdata = prev_slew_gain_q;
      REG_BALANCE_RAW:    prdata = balance_raw_q;
      REG_BALANCE_HELD:   prdata = balance_held_q;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_gain_q      <= RST_SLEW_GAIN;
      inv_slew_gain_q  <= RST_INV_SLEW_GAIN;
      prev_slew_gain_q <= RST_PREV_SLEW_GAIN;
      balance_raw_q    <= RST_BALANCE_RAW;
      balance_held_q   <= RST_BALANCE_HELD;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_SLEW_GAIN:      slew_gain_q      <= pwdata;
        REG_INV_SLEW_GAIN:  inv_slew_gain_q  <= pwdata;
        REG_PREV_SLEW_GAIN: prev_slew_gain_q <= pwdata;
        REG_BALANCE_RAW:    balance_raw_q    <= pwdata;
        REG_BALANCE_HELD:   balance_held_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // Terms shared by several sequencer steps.
  assign slew_v    = SW'(in_if.sample_in) - SW'(prior_input_q);
  assign x_mag     = mag(SW'(x_q));
  assign pm_mag    = mag(SW'(prior_mix_q));
  assign ps_mag    = mag(SW'(prior_slew_q));
  assign res_gt_pi = mul_res > RW'(HALF_PI_Q);
  assign res_sin   = mul_res[SIN_W-1:0];
  assign res_q1    = (mul_res > RW'(Q_ONE)) ? Q_ONE : mul_res[SIN_W-1:0];
  assign lim_v     = sat_w(sval(slew_neg_q, mul_res));
  assign y_cap     = (acc_q > CAP_HI) ? CAP_HI : ((acc_q < CAP_LO) ? CAP_LO : acc_q);

  // Restoring division by a series constant, one quotient bit per cycle.
  assign trial    = {rem_q, dq_q[SQ_W-1]};
  assign div_ge   = trial >= {1'b0, sine_div(k_q)};
  assign rem_full = div_ge ? (trial - {1'b0, sine_div(k_q)}) : trial;
  assign dq_n     = {dq_q[SQ_W-2:0], div_ge};
  assign t_n      = (dq_n >= SQ_W'(Q_ONE)) ? '0 : (Q_ONE - dq_n[SIN_W-1:0]);

  // Sequencer: walks the sample through the shared multiplier.
  always_comb begin
    state_d       = state_q;
    ret_d         = ret_q;
    x_d           = x_q;
    lim_d         = lim_q;
    mix_d         = mix_q;
    prior_input_d = prior_input_q;
    prior_mix_d   = prior_mix_q;
    prior_slew_d  = prior_slew_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q & ~out_if.ready;
    slew_neg_d    = slew_neg_q;
    yneg_d        = yneg_q;
    acc_d         = acc_q;
    sx_d          = sx_q;
    st_d          = st_q;
    sx2_d         = sx2_q;
    dq_d          = dq_q;
    rem_d         = rem_q;
    k_d           = k_q;
    dcnt_d        = dcnt_q;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    in_if.ready   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          x_d           = in_if.sample_in;
          prior_input_d = in_if.sample_in;
          slew_neg_d    = slew_v[SW-1];
          mul_start     = 1'b1;
          mul_a         = mag(slew_v);
          mul_b         = slew_gain_q;
          state_d       = ST_SLEW;
        end
      end
      ST_SLEW: begin
        if (mul_done) begin
          mul_start = 1'b1;
          if (res_gt_pi) begin
            mul_a   = MW'(Q_ONE);
            mul_b   = inv_slew_gain_q;
            state_d = ST_LM;
          end else begin
            sx_d    = res_sin;
            ret_d   = RET_SLEW;
            mul_a   = MW'(res_sin);
            mul_b   = 32'(res_sin);
            state_d = ST_SIN_SQ;
          end
        end
      end
      ST_SIN_SQ: begin
        if (mul_done) begin
          sx2_d     = mul_res[SQ_W-1:0];
          st_d      = Q_ONE;
          k_d       = '0;
          mul_start = 1'b1;
          mul_a     = MW'(mul_res[SQ_W-1:0]);
          mul_b     = 32'(Q_ONE);
          state_d   = ST_SIN_MT;
        end
      end
      ST_SIN_MT: begin
        if (mul_done) begin
          dq_d    = mul_res[SQ_W-1:0];
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = ST_SIN_DIV;
        end
      end
      ST_SIN_DIV: begin
        dq_d   = dq_n;
        rem_d  = rem_full[DIV_W-1:0];
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'(SQ_W - 1)) begin
          st_d      = t_n;
          mul_start = 1'b1;
          mul_b     = 32'(t_n);
          if (k_q == 3'(SIN_TERMS - 1)) begin
            mul_a   = MW'(sx_q);
            state_d = ST_SIN_FIN;
          end else begin
            k_d     = k_q + 3'd1;
            mul_a   = MW'(sx2_q);
            state_d = ST_SIN_MT;
          end
        end
      end
      ST_SIN_FIN: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MW'(res_q1);
          if (ret_q == RET_SLEW) begin
            mul_b   = inv_slew_gain_q;
            state_d = ST_LM;
          end else begin
            mul_b   = DRIVE_INV_Q;
            state_d = ST_OUT;
          end
        end
      end
      ST_LM: begin
        if (mul_done) begin
          lim_d     = lim_v;
          acc_d     = SW'(lim_v);
          mul_start = 1'b1;
          mul_a     = pm_mag;
          mul_b     = balance_held_q;
          state_d   = ST_MIXH;
        end
      end
      ST_MIXH: begin
        if (mul_done) begin
          acc_d     = acc_q + sval(prior_mix_q[W-1], mul_res);
          mul_start = 1'b1;
          mul_a     = x_mag;
          mul_b     = balance_raw_q;
          state_d   = ST_MIXR;
        end
      end
      ST_MIXR: begin
        if (mul_done) begin
          acc_d   = acc_q + sval(x_q[W-1], mul_res);
          state_d = ST_MIXS;
        end
      end
      ST_MIXS: begin
        // Saturate the mix, then form the comb term (1.0 for large inputs).
        mix_d     = sat_w(acc_q);
        mul_start = 1'b1;
        if (x_mag >= MW'(Q_ONE)) begin
          mul_a   = ps_mag;
          mul_b   = 32'(Q_ONE);
          state_d = ST_SUB1;
        end else begin
          mul_a   = x_mag;
          mul_b   = 32'(x_mag[SIN_W-1:0]);
          state_d = ST_COMB;
        end
      end
      ST_COMB: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = ps_mag;
          mul_b     = 32'(res_q1);
          state_d   = ST_SUB1;
        end
      end
      ST_SUB1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_res[MW-1:0];
          mul_b     = prev_slew_gain_q;
          state_d   = ST_SUB2;
        end
      end
      ST_SUB2: begin
        if (mul_done) begin
          acc_d   = SW'(mix_q) - sval(prior_slew_q[W-1], mul_res);
          state_d = ST_Y;
        end
      end
      ST_Y: begin
        yneg_d    = acc_q[SW-1];
        mul_start = 1'b1;
        mul_a     = mag(y_cap);
        mul_b     = DRIVE_GAIN_Q;
        state_d   = ST_DRV;
      end
      ST_DRV: begin
        if (mul_done) begin
          mul_start = 1'b1;
          if (res_gt_pi) begin
            mul_a   = MW'(Q_ONE);
            mul_b   = DRIVE_INV_Q;
            state_d = ST_OUT;
          end else begin
            sx_d    = res_sin;
            ret_d   = RET_DRIVE;
            mul_a   = MW'(res_sin);
            mul_b   = 32'(res_sin);
            state_d = ST_SIN_SQ;
          end
        end
      end
      ST_OUT: begin
        if (mul_done) begin
          acc_d   = sval(yneg_q, mul_res);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || out_if.ready) begin
          out_d        = sat_w(acc_q);
          out_valid_d  = 1'b1;
          prior_mix_d  = mix_q;
          prior_slew_d = lim_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and sample history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ret_q         <= RET_SLEW;
      out_valid_q   <= 1'b0;
      prior_input_q <= '0;
      prior_mix_q   <= '0;
      prior_slew_q  <= '0;
      k_q           <= '0;
      dcnt_q        <= '0;
    end else begin
      state_q       <= state_d;
      ret_q         <= ret_d;
      out_valid_q   <= out_valid_d;
      prior_input_q <= prior_input_d;
      prior_mix_q   <= prior_mix_d;
      prior_slew_q  <= prior_slew_d;
      k_q           <= k_d;
      dcnt_q        <= dcnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    lim_q      <= lim_d;
    mix_q      <= mix_d;
    out_q      <= out_d;
    slew_neg_q <= slew_neg_d;
    yneg_q     <= yneg_d;
    acc_q      <= acc_d;
    sx_q       <= sx_d;
    st_q       <= st_d;
    sx2_q      <= sx2_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = out_q;

  // The input history moves only on a transfer into the block.
  a_prior_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.valid && in_if.ready) |=> $stable(prior_input_q))
    else $error("prior input changed without an input transfer");

  // Mix and slew history move only when a result enters the output register.
  a_prior_mix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_EMIT) |=> ($stable(prior_mix_q) && $stable(prior_slew_q)))
    else $error("history changed outside result hand-off");

  // The series index stays within its five terms.
  a_series_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIN_MT || state_q == ST_SIN_DIV) |-> (k_q < 3'(SIN_TERMS)))
    else $error("sine series index out of range");

  // Leaving the hand-off state always presents a result.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_q || out_if.ready)) |=> out_valid_q)
    else $error("result lost at hand-off");

endmodule
